>>> design/sa_pkg.sv
// Shared types and constants for the stack allocator.
// No dependencies; every file of the block but sa_ram imports this package.
`timescale 1ns / 1ps

package sa_pkg;

  localparam int MarkerDepth = 64;
  localparam int OffsetBits  = 21;
  localparam int PtrBits     = $clog2(MarkerDepth + 1);
  localparam int MemAddrBits = $clog2(MarkerDepth);
  localparam int AddrBits    = 32;
  localparam int AlignBits   = 4;
  localparam int PadBits     = 2 ** AlignBits - 1;
  localparam int NextBits    = OffsetBits + 2;
  localparam int StatusBits  = 3;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 32;

  localparam logic [OffsetBits-1:0] RegionSizeReset = OffsetBits'(1048576);

  localparam logic [CfgIdxBits-1:0] CfgRegionSize = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgRegionBase = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_POP   = 2'd2,
    ACT_RESET = 2'd3
  } action_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_EMPTY_FREE = 3'd2,
    ST_POP_BEYOND = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_POP
  } state_e;

  typedef struct packed {
    logic [OffsetBits-1:0] region_size;
    logic [AddrBits-1:0]   region_base;
  } cfg_t;

  typedef struct packed {
    logic [AddrBits-1:0] here;
    logic [PadBits-1:0]  pad;
  } align_t;

  typedef struct packed {
    logic                  valid;
    logic [AddrBits-1:0]   address;
    status_e               status;
    logic [OffsetBits-1:0] used;
    logic [OffsetBits-1:0] peak;
    logic [PtrBits-1:0]    count;
  } res_t;

endpackage

>>> design/stack_allocator_with_markers.sv
// Top level of the LIFO bump allocator: configuration registers and block wiring.
// Depends on sa_pkg, sa_ram, sa_align and sa_ctrl.
`timescale 1ns / 1ps

//  Channel   Handshake              Payload
//  -------   ---------------------  ----------------------------------------------
//  command   start & !busy          action_i, request_size_i, align_log2_i,
//                                   target_offset_i
//  result    done_o (one cycle)     address_o, status_o, used_bytes_o,
//                                   peak_bytes_o, marker_count_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
//  Steps per command, from the accepting edge to the result beat:
//    reset action, free or pop with no markers, pop beyond top: registered on accept.
//    allocate: align terms registered, then fit check and marker write.
//    free: one marker RAM read of registered latency, then the result.
//    pop: one marker read per cycle; the walk stops at the first
//    kept marker or an empty stack, so it reads discarded markers plus at most one.
//  Reset clears top, peak and marker count at once; the marker RAM gets no
//  clearing pass since entries above the count are never used. busy is high from
//  the accepting edge until the result beat; a new command may be taken in the
//  cycle the result is shown. The receiver cannot stall the result beat.

module stack_allocator_with_markers (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic [sa_pkg::OffsetBits-1:0] request_size_i,
  input  logic [sa_pkg::AlignBits-1:0]  align_log2_i,
  input  logic [sa_pkg::OffsetBits-1:0] target_offset_i,
  // result channel
  output logic                          done_o,
  output logic [sa_pkg::AddrBits-1:0]   address_o,
  output logic [sa_pkg::StatusBits-1:0] status_o,
  output logic [sa_pkg::OffsetBits-1:0] used_bytes_o,
  output logic [sa_pkg::OffsetBits-1:0] peak_bytes_o,
  output logic [sa_pkg::PtrBits-1:0]    marker_count_o,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [sa_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [sa_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import sa_pkg::*;

  cfg_t                   cfg_q, cfg_d;
  align_t                 align;
  res_t                   res;
  logic [OffsetBits-1:0]  top;
  logic                   mem_we;
  logic [MemAddrBits-1:0] mem_waddr;
  logic [OffsetBits-1:0]  mem_wdata;
  logic [MemAddrBits-1:0] mem_raddr;
  logic [OffsetBits-1:0]  mem_rdata;

  // Configuration registers: take a write in the cycle it is offered.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRegionSize: cfg_d.region_size = cfg_wdata_i[OffsetBits-1:0];
        CfgRegionBase: cfg_d.region_base = cfg_wdata_i[AddrBits-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_size <= RegionSizeReset;
      cfg_q.region_base <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Padding is worked out from the live top so an allocate can register it
  // on the accepting edge.
  sa_align u_align (
    .base_i       (cfg_q.region_base),
    .top_i        (top),
    .align_log2_i (align_log2_i),
    .align_o      (align)
  );

  sa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .action_i      (action_i),
    .size_i        (request_size_i),
    .target_i      (target_offset_i),
    .region_size_i (cfg_q.region_size),
    .align_i       (align),
    .top_o         (top),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .res_o         (res)
  );

  // Marker stack: one entry per pushed top offset. Writes and reads never
  // target the same entry, since a write goes to the pointer and reads lie below it.
  sa_ram #(
    .Width (OffsetBits),
    .Depth (MarkerDepth)
  ) u_marker_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign done_o         = res.valid;
  assign address_o      = res.address;
  assign status_o       = res.status;
  assign used_bytes_o   = res.used;
  assign peak_bytes_o   = res.peak;
  assign marker_count_o = res.count;

endmodule

>>> design/sa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sa_align.sv
// Alignment front end: absolute top address and padding to the next boundary.
// Depends on sa_pkg.
`timescale 1ns / 1ps

module sa_align (
  input  logic [sa_pkg::AddrBits-1:0]   base_i,
  input  logic [sa_pkg::OffsetBits-1:0] top_i,
  input  logic [sa_pkg::AlignBits-1:0]  align_log2_i,
  output sa_pkg::align_t                align_o
);
  import sa_pkg::*;

  logic [AddrBits-1:0] here;
  logic [PadBits:0]    bound;
  logic [PadBits:0]    mask_wide;
  logic [PadBits-1:0]  neg_low;

  assign here      = base_i + AddrBits'(top_i);
  // only the low bits of the negated address survive the mask
  assign neg_low   = ~here[PadBits-1:0] + PadBits'(1);
  assign bound     = (PadBits + 1)'(1) << align_log2_i;
  assign mask_wide = bound - (PadBits + 1)'(1);

  assign align_o.here = here;
  assign align_o.pad  = neg_low & mask_wide[PadBits-1:0];

endmodule

>>> design/sa_ctrl.sv
// Sequencer for the allocator: top/peak/pointer state, marker RAM access, result beat.
// Depends on sa_pkg; drives the marker RAM and takes the alignment terms from sa_align.
`timescale 1ns / 1ps

module sa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     action_i,
  input  logic [sa_pkg::OffsetBits-1:0]  size_i,
  input  logic [sa_pkg::OffsetBits-1:0]  target_i,
  input  logic [sa_pkg::OffsetBits-1:0]  region_size_i,
  input  sa_pkg::align_t                 align_i,
  output logic [sa_pkg::OffsetBits-1:0]  top_o,
  output logic                           mem_we_o,
  output logic [sa_pkg::MemAddrBits-1:0] mem_waddr_o,
  output logic [sa_pkg::OffsetBits-1:0]  mem_wdata_o,
  output logic [sa_pkg::MemAddrBits-1:0] mem_raddr_o,
  input  logic [sa_pkg::OffsetBits-1:0]  mem_rdata_i,
  output sa_pkg::res_t                   res_o
);
  import sa_pkg::*;

  state_e                state_q, state_d;
  logic [OffsetBits-1:0] top_q, top_d;
  logic [OffsetBits-1:0] peak_q, peak_d;
  logic [PtrBits-1:0]    ptr_q, ptr_d;
  logic [OffsetBits-1:0] size_q, size_d;
  logic [OffsetBits-1:0] target_q, target_d;
  logic [AddrBits-1:0]   here_q, here_d;
  logic [PadBits-1:0]    pad_q, pad_d;
  res_t                  res_q, res_d;

  action_e               act;
  logic                  accept;
  logic                  ptr_empty;
  logic                  ptr_full;
  logic                  pop_beyond;
  logic [PtrBits-1:0]    ptr_dec;
  logic [PtrBits-1:0]    ptr_dec2;
  logic [PtrBits-1:0]    ptr_inc;
  logic [NextBits-1:0]   next_off;
  logic [OffsetBits-1:0] next_top;
  logic                  fits;
  logic                  discard;

  assign act        = action_e'(action_i);
  assign accept     = start_i && (state_q == S_IDLE);
  assign busy_o     = (state_q != S_IDLE);
  assign ptr_empty  = (ptr_q == '0);
  assign ptr_full   = (ptr_q == PtrBits'(MarkerDepth));
  assign pop_beyond = (target_i > top_q);
  assign ptr_dec    = ptr_q - PtrBits'(1);
  assign ptr_dec2   = ptr_q - PtrBits'(2);
  assign ptr_inc    = ptr_q + PtrBits'(1);
  assign next_off   = NextBits'(top_q) + NextBits'(pad_q) + NextBits'(size_q);
  assign next_top   = next_off[OffsetBits-1:0];
  assign fits       = (next_off <= NextBits'(region_size_i));
  assign discard    = (mem_rdata_i > target_q);

  assign top_o       = top_q;
  assign mem_waddr_o = ptr_q[MemAddrBits-1:0];
  assign mem_wdata_o = top_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_ALLOC: state_d = S_ALLOC;
            ACT_FREE:  state_d = ptr_empty ? S_IDLE : S_FREE;
            ACT_POP:   state_d = (pop_beyond || ptr_empty) ? S_IDLE : S_POP;
            ACT_RESET: state_d = S_IDLE;
          endcase
        end
      end
      S_ALLOC: state_d = S_IDLE;
      S_FREE:  state_d = S_IDLE;
      S_POP: begin
        if (!(discard && (ptr_dec != '0))) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    top_d       = top_q;
    peak_d      = peak_q;
    ptr_d       = ptr_q;
    size_d      = size_q;
    target_d    = target_q;
    here_d      = here_q;
    pad_d       = pad_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = ptr_dec[MemAddrBits-1:0];
    res_d.valid   = 1'b0;
    res_d.address = '0;
    res_d.status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          size_d   = size_i;
          target_d = target_i;
          here_d   = align_i.here;
          pad_d    = align_i.pad;
          unique case (act)
            ACT_ALLOC: ;
            ACT_FREE: begin
              if (ptr_empty) begin
                res_d.valid  = 1'b1;
                res_d.status = ST_EMPTY_FREE;
              end
            end
            ACT_POP: begin
              if (pop_beyond) begin
                res_d.valid  = 1'b1;
                res_d.status = ST_POP_BEYOND;
              end else if (ptr_empty) begin
                top_d       = target_i;
                res_d.valid = 1'b1;
              end
            end
            ACT_RESET: begin
              top_d       = '0;
              peak_d      = '0;
              ptr_d       = '0;
              res_d.valid = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        res_d.valid = 1'b1;
        if (!fits) begin
          res_d.status = ST_NO_SPACE;
        end else if (ptr_full) begin
          res_d.status = ST_FULL;
        end else begin
          mem_we_o      = 1'b1;
          ptr_d         = ptr_inc;
          top_d         = next_top;
          res_d.address = here_q + AddrBits'(pad_q);
          if (next_top > peak_q) begin
            peak_d = next_top;
          end
        end
      end
      S_FREE: begin
        top_d       = mem_rdata_i;
        ptr_d       = ptr_dec;
        res_d.valid = 1'b1;
      end
      S_POP: begin
        if (discard) begin
          ptr_d       = ptr_dec;
          mem_raddr_o = ptr_dec2[MemAddrBits-1:0];
        end
        if (!(discard && (ptr_dec != '0))) begin
          top_d       = target_q;
          res_d.valid = 1'b1;
        end
      end
    endcase
    res_d.used  = top_d;
    res_d.peak  = peak_d;
    res_d.count = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      peak_q  <= '0;
      ptr_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      peak_q  <= peak_d;
      ptr_q   <= ptr_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    target_q <= target_d;
    here_q   <= here_d;
    pad_q    <= pad_d;
  end

  assign res_o = res_q;

endmodule

>>> tb/tb.sv
// Self-checking bench for the LIFO bump allocator with rollback markers.
// Depends on sa_pkg and stack_allocator_with_markers; the expected beats come from an
// in-bench model of the top offset, peak, marker stack and region registers.
`timescale 1ns / 1ps

module tb;
  import sa_pkg::*;

  localparam int unsigned WatchdogCycles = 4000;
  localparam logic [OffsetBits-1:0] OffsetAll = {OffsetBits{1'b1}};

  // Expected content of one result beat.
  typedef struct {
    logic [AddrBits-1:0]   address;
    status_e               status;
    logic [OffsetBits-1:0] used;
    logic [OffsetBits-1:0] peak;
    logic [PtrBits-1:0]    count;
  } alloc_beat_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             action_i;
  logic [OffsetBits-1:0]  request_size_i;
  logic [AlignBits-1:0]   align_log2_i;
  logic [OffsetBits-1:0]  target_offset_i;
  logic                   done_o;
  logic [AddrBits-1:0]    address_o;
  logic [StatusBits-1:0]  status_o;
  logic [OffsetBits-1:0]  used_bytes_o;
  logic [OffsetBits-1:0]  peak_bytes_o;
  logic [PtrBits-1:0]     marker_count_o;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  // Allocator model state and its copy of the region registers.
  bit [63:0]       top_bytes;
  bit [63:0]       peak_seen;
  bit [63:0]       saved_tops[MarkerDepth];
  int unsigned     saved_cnt;
  bit [OffsetBits-1:0] region_len;
  bit [AddrBits-1:0]   region_start;

  alloc_beat_t     pending_beats[$];
  alloc_beat_t     want;
  int unsigned     err_cnt;
  int unsigned     quiet_cycles;
  int unsigned     gap_pct;

  stack_allocator_with_markers u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .align_log2_i   (align_log2_i),
    .target_offset_i(target_offset_i),
    .done_o         (done_o),
    .address_o      (address_o),
    .status_o       (status_o),
    .used_bytes_o   (used_bytes_o),
    .peak_bytes_o   (peak_bytes_o),
    .marker_count_o (marker_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted command to the model and return the beat it must produce.
  function automatic alloc_beat_t apply_command(action_e act, logic [OffsetBits-1:0] size,
                                                logic [AlignBits-1:0] alog2,
                                                logic [OffsetBits-1:0] target);
    alloc_beat_t beat;
    bit [63:0]   here;
    bit [63:0]   pad;
    bit [63:0]   limit;
    bit [63:0]   nxt_top;
    beat.address = '0;
    beat.status  = ST_OK;
    case (act)
      ACT_ALLOC: begin
        // Pad the absolute 32-bit address up to the boundary.
        here    = ({32'd0, region_start} + top_bytes) & 64'hFFFF_FFFF;
        pad     = (64'd0 - here) & ((64'd1 << alog2) - 64'd1);
        limit   = (region_len < OffsetAll) ? 64'(region_len) : 64'(OffsetAll);
        nxt_top = top_bytes + pad + 64'(size);
        // The space check wins over the full stack.
        if (nxt_top > limit) begin
          beat.status = ST_NO_SPACE;
        end else if (saved_cnt >= MarkerDepth) begin
          beat.status = ST_FULL;
        end else begin
          saved_tops[saved_cnt] = top_bytes;
          saved_cnt++;
          beat.address = AddrBits'(here + pad);
          top_bytes    = nxt_top;
          if (top_bytes > peak_seen) peak_seen = top_bytes;
        end
      end
      ACT_FREE: begin
        if (saved_cnt == 0) begin
          beat.status = ST_EMPTY_FREE;
        end else begin
          saved_cnt--;
          top_bytes = saved_tops[saved_cnt];
        end
      end
      ACT_POP: begin
        if (64'(target) > top_bytes) begin
          beat.status = ST_POP_BEYOND;
        end else begin
          while (saved_cnt > 0 && saved_tops[saved_cnt-1] > 64'(target)) saved_cnt--;
          top_bytes = 64'(target);
        end
      end
      default: begin
        top_bytes = 0;
        peak_seen = 0;
        saved_cnt = 0;
      end
    endcase
    beat.used  = OffsetBits'(top_bytes);
    beat.peak  = OffsetBits'(peak_seen);
    beat.count = PtrBits'(saved_cnt);
    return beat;
  endfunction

  function automatic logic [OffsetBits-1:0] any_offset();
    return OffsetBits'($urandom_range(0, 32'(OffsetAll)));
  endfunction

  // Send one command: hold off at random, then hold start until the command is accepted.
  task automatic issue(action_e act, logic [OffsetBits-1:0] size,
                       logic [AlignBits-1:0] alog2, logic [OffsetBits-1:0] target);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    action_i        = act;
    request_size_i  = size;
    align_log2_i    = alog2;
    target_offset_i = target;
    start           = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_beats.insert(pending_beats.size(), apply_command(act, size, alog2, target));
  endtask

  // Drop start and wait until every expected beat is back.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Region registers change only while the block sits idle.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    if (idx == CfgRegionSize) region_len = data[OffsetBits-1:0];
    else region_start = data;
  endtask

  // Free and pop on an empty stack, exact fits, padding, zero size and oversize requests.
  task automatic test_corner_commands();
    issue(ACT_FREE,  any_offset(), 4'd15, any_offset());
    issue(ACT_POP,   any_offset(), 4'd0,  21'd1);
    issue(ACT_POP,   any_offset(), 4'd7,  21'd0);
    issue(ACT_ALLOC, 21'd0,        4'd0,  any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd0,  any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd12, any_offset());
    issue(ACT_ALLOC, 21'd5,        4'd15, any_offset());
    issue(ACT_FREE,  any_offset(), 4'd3,  any_offset());
    issue(ACT_POP,   any_offset(), 4'd0,  21'd1);
    issue(ACT_POP,   any_offset(), 4'd0,  21'd0);
    issue(ACT_ALLOC, 21'd1048576,  4'd0,  any_offset());
    issue(ACT_ALLOC, 21'd0,        4'd0,  any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd0,  any_offset());
    issue(ACT_POP,   any_offset(), 4'd0,  OffsetAll);
    issue(ACT_FREE,  any_offset(), 4'd0,  any_offset());
    issue(ACT_RESET, OffsetAll,    4'd15, OffsetAll);
    issue(ACT_ALLOC, OffsetAll,    4'd0,  21'd0);
    issue(ACT_ALLOC, 21'd4096,     4'd12, 21'd0);
  endtask

  // Fill every marker, then check that a fitting request reports a full stack
  // while an oversize one still reports no space.
  task automatic test_marker_stack_full();
    issue(ACT_RESET, any_offset(), 4'd0, any_offset());
    for (int i = 0; i < MarkerDepth; i++)
      issue(ACT_ALLOC, 21'($urandom_range(0, 64)), 4'($urandom_range(0, 4)), any_offset());
    issue(ACT_ALLOC, 21'd0,        4'd0,  any_offset());
    issue(ACT_ALLOC, OffsetAll,    4'd0,  any_offset());
    issue(ACT_POP,   any_offset(), 4'd0,  OffsetBits'(saved_tops[MarkerDepth/2]));
    issue(ACT_FREE,  any_offset(), 4'd0,  any_offset());
    issue(ACT_POP,   any_offset(), 4'd0,  21'd0);
  endtask

  // Base near or at the top of the address space wraps the address; tiny and zero regions; all-ones writes.
  task automatic test_region_edges();
    drain();
    write_reg(CfgRegionBase, 32'hFFF0_0000);
    write_reg(CfgRegionSize, 32'd1048576);
    issue(ACT_RESET, any_offset(), 4'd0, any_offset());
    issue(ACT_ALLOC, 21'd1048575,  4'd0, any_offset());
    issue(ACT_ALLOC, 21'd0,        4'd0, any_offset());
    issue(ACT_FREE,  any_offset(), 4'd0, any_offset());
    issue(ACT_ALLOC, 21'd0,        4'd4, any_offset());
    drain();
    write_reg(CfgRegionSize, 32'd0);
    issue(ACT_RESET, any_offset(), 4'd0, any_offset());
    issue(ACT_ALLOC, 21'd0,        4'd0, any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd9, any_offset());
    drain();
    write_reg(CfgRegionSize, 32'd1);
    write_reg(CfgRegionBase, 32'h0000_0003);
    issue(ACT_ALLOC, 21'd1,        4'd0, any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd0, any_offset());
    issue(ACT_POP,   any_offset(), 4'd0, 21'd0);
    issue(ACT_ALLOC, 21'd0,        4'd1, any_offset());
    drain();
    // Upper data bits fall away on the size register.
    write_reg(CfgRegionSize, 32'hFFFF_FFFF);
    write_reg(CfgRegionBase, 32'hFFFF_FFFF);
    issue(ACT_RESET, any_offset(), 4'd0, any_offset());
    issue(ACT_ALLOC, 21'h1F_FFFE,  4'd1, any_offset());
    issue(ACT_ALLOC, 21'd1,        4'd0, any_offset());
  endtask

  function automatic logic [OffsetBits-1:0] pick_size();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = 32'(region_len) / 48 + 1;
    if (roll < 5) return any_offset();
    if (roll < 10) return '0;
    return OffsetBits'($urandom_range(0, span));
  endfunction

  // Mostly well-formed allocate/free/pop traffic, with some resets, and valid pop targets;
  // a slice of it is oversize, beyond-top or otherwise broken.
  task automatic test_random_traffic(int unsigned n_items, int unsigned pct,
                                     logic [CfgDataBits-1:0] size_reg,
                                     logic [CfgDataBits-1:0] base_reg);
    int unsigned        roll;
    int unsigned        pick;
    logic [AlignBits-1:0] alog2;
    logic [OffsetBits-1:0] target;
    drain();
    write_reg(CfgRegionSize, size_reg);
    write_reg(CfgRegionBase, base_reg);
    gap_pct = pct;
    issue(ACT_RESET, any_offset(), 4'($urandom_range(15)), any_offset());
    for (int i = 0; i < n_items; i++) begin
      roll  = $urandom_range(99);
      alog2 = ($urandom_range(9) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
      if (roll < 52) begin
        issue(ACT_ALLOC, pick_size(), alog2, any_offset());
      end else if (roll < 77) begin
        issue(ACT_FREE, any_offset(), alog2, any_offset());
      end else if (roll < 97) begin
        pick = $urandom_range(99);
        if (pick < 55 && saved_cnt > 0)
          target = OffsetBits'(saved_tops[$urandom_range(0, saved_cnt - 1)]);
        else if (pick < 85)
          target = OffsetBits'($urandom_range(0, 32'(top_bytes)));
        else
          target = any_offset();
        issue(ACT_POP, any_offset(), alog2, target);
      end else begin
        issue(ACT_RESET, any_offset(), alog2, any_offset());
      end
    end
  endtask

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: result beat with none expected (status %0d)", $time, status_o);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        if (address_o !== want.address) begin
          $display("%0t: address expected %h got %h", $time, want.address, address_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          err_cnt++;
        end
        if (used_bytes_o !== want.used) begin
          $display("%0t: used_bytes expected %0d got %0d", $time, want.used, used_bytes_o);
          err_cnt++;
        end
        if (peak_bytes_o !== want.peak) begin
          $display("%0t: peak_bytes expected %0d got %0d", $time, want.peak, peak_bytes_o);
          err_cnt++;
        end
        if (marker_count_o !== want.count) begin
          $display("%0t: marker_count expected %0d got %0d", $time, want.count,
                   marker_count_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: any accepted command or result beat clears the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogCycles) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Drive every input to a known value before reset releases.
    rst_ni          = 1'b0;
    start           = 1'b0;
    action_i        = ACT_ALLOC;
    request_size_i  = '0;
    align_log2_i    = '0;
    target_offset_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgRegionSize;
    cfg_wdata_i     = '0;
    err_cnt         = 0;
    quiet_cycles    = 0;
    gap_pct         = 0;
    region_len      = RegionSizeReset;
    region_start    = '0;
    top_bytes       = 0;
    peak_seen       = 0;
    saved_cnt       = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_commands();
    test_marker_stack_full();
    test_region_edges();
    // Sender idles rarely, then mostly, then never.
    test_random_traffic(400, 19, 32'd1048576, $urandom());
    test_random_traffic(400, 79, 32'($urandom_range(4096, 65536)), $urandom() | 32'd1);
    test_random_traffic(400, 0,  32'h001F_FFFF, 32'hFFF0_0000);

    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
